// ===== hdl/priority_led_sequencer_defines.svh =====
// Assertion macros for the priority LED sequencer.
// Define ASSERT_OFF to compile the assertions out.
`ifndef PRIORITY_LED_SEQUENCER_DEFINES_SVH
`define PRIORITY_LED_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define PLS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pls assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PLS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pls assertion failed");

`else

`define PLS_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define PLS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/pls_pkg.sv =====
`timescale 1ns / 1ps

package pls_pkg;

    // Default sizes.
    localparam int DEF_LED_COUNT     = 4;
    localparam int DEF_PATTERN_COUNT = 6;

    // Pattern ROM geometry.
    localparam int ROM_PATTERNS = 6;
    localparam int ROM_STEPS    = 3;

    // Longest walk through the steps of one LED.
    localparam int WALK_LIMIT = 16;

    // Field widths.
    localparam int CODE_W = 3;
    localparam int MS_W   = 11;

    // Stopped position and "no active pattern".
    localparam logic [CODE_W-1:0] CODE_NONE = 3'd7;

    // Function codes of an input item.
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_RUN  = 2'd1;
    localparam logic [1:0] FUNC_STOP = 2'd2;

    // Step kinds.
    localparam logic [1:0] KIND_WAIT = 2'd0;
    localparam logic [1:0] KIND_LOOP = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // Wait times in milliseconds.
    localparam logic [MS_W-1:0] MS_0    = 11'd0;
    localparam logic [MS_W-1:0] MS_1    = 11'd1;
    localparam logic [MS_W-1:0] MS_50   = 11'd50;
    localparam logic [MS_W-1:0] MS_200  = 11'd200;
    localparam logic [MS_W-1:0] MS_450  = 11'd450;
    localparam logic [MS_W-1:0] MS_800  = 11'd800;
    localparam logic [MS_W-1:0] MS_1000 = 11'd1000;
    localparam logic [MS_W-1:0] MS_1950 = 11'd1950;

    typedef struct packed {
        logic [1:0] func;
        logic [1:0] led_index;
        logic [2:0] pattern_index;
    } in_item_t;

    typedef struct packed {
        logic [3:0] led_levels;
        logic [3:0] timing_mask;
    } out_item_t;

    typedef struct packed {
        logic            level;
        logic [1:0]      kind;
        logic [MS_W-1:0] ms;
    } step_t;

    // Per-LED control part of a memory row.
    typedef struct packed {
        logic [CODE_W-1:0] active;
        logic [MS_W-1:0]   countdown;
        logic              lit;
    } led_ctl_t;

    // Result flags of one walk step.
    typedef struct packed {
        logic done;
    } step_flags_t;

    localparam step_t STEP_STOP = '{1'b0, KIND_END, MS_0};

    localparam step_t ROM_TABLE [ROM_PATTERNS][ROM_STEPS] = '{
        '{'{1'b1, KIND_WAIT, MS_1000}, '{1'b0, KIND_LOOP, MS_0},   '{1'b0, KIND_END,  MS_0}},
        '{'{1'b1, KIND_WAIT, MS_1000}, '{1'b0, KIND_LOOP, MS_0},   '{1'b0, KIND_END,  MS_0}},
        '{'{1'b1, KIND_WAIT, MS_200},  '{1'b0, KIND_WAIT, MS_800}, '{1'b0, KIND_LOOP, MS_0}},
        '{'{1'b1, KIND_WAIT, MS_50},   '{1'b0, KIND_WAIT, MS_450}, '{1'b0, KIND_LOOP, MS_0}},
        '{'{1'b1, KIND_WAIT, MS_50},   '{1'b0, KIND_WAIT, MS_1950},'{1'b0, KIND_LOOP, MS_0}},
        '{'{1'b1, KIND_WAIT, MS_1},    '{1'b0, KIND_WAIT, MS_0},   '{1'b0, KIND_END,  MS_0}}
    };

    // A position past the stored steps reads as a stop step.
    function automatic step_t rom_step(input logic [CODE_W-1:0] pat,
                                       input logic [CODE_W-1:0] pos);
        step_t st;
        st = STEP_STOP;
        if ((32'(pat) < ROM_PATTERNS) && (32'(pos) < ROM_STEPS))
        begin
            st = ROM_TABLE[pat][pos[1:0]];
        end
        return st;
    endfunction

endpackage

// ===== hdl/priority_led_sequencer.sv =====
// Sequence: a run or stop goes through read, load, the walk and write-back, then the final
// state; a stop or a winning run walks at least one step when walking is enabled, a losing run
// skips the walk. A tick does read, load, the walk if a countdown runs out, and write-back per LED.
// Throughput: one item at a time; the next is taken once the result is in the output register.
// Reset (rst_n, asynchronous, active low): all patterns stopped, no active pattern,
// countdowns zero, LEDs off, walk_enable set; unwritten rows read as the reset row.
`timescale 1ns / 1ps

`include "priority_led_sequencer_defines.svh"

module priority_led_sequencer #(
    parameter int LED_COUNT     = pls_pkg::DEF_LED_COUNT,
    parameter int PATTERN_COUNT = pls_pkg::DEF_PATTERN_COUNT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  pls_pkg::in_item_t in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output pls_pkg::out_item_t out_item
);

    // Index widths. A single LED or pattern still gets one address bit.
    localparam int LED_W   = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int PAT_W   = (PATTERN_COUNT > 1) ? $clog2(PATTERN_COUNT) : 1;
    localparam int GUARD_W = $clog2(pls_pkg::WALK_LIMIT + 1);
    localparam int CTL_W   = $bits(pls_pkg::led_ctl_t);
    localparam int ROW_W   = PATTERN_COUNT * pls_pkg::CODE_W + CTL_W;

    localparam logic [LED_W-1:0]   LAST_LED   = LED_W'(LED_COUNT - 1);
    localparam logic [GUARD_W-1:0] LAST_GUARD = GUARD_W'(pls_pkg::WALK_LIMIT - 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_WALK = 3'd3;
    localparam logic [2:0] ST_WB   = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    localparam pls_pkg::led_ctl_t CTL_RESET = '{pls_pkg::CODE_NONE, '0, 1'b0};

    // Control registers.
    logic [2:0]         state_reg, state_next;
    logic               walk_enable_reg;
    logic [LED_COUNT-1:0] lit_bits_reg, lit_bits_next;
    logic [LED_COUNT-1:0] run_bits_reg, run_bits_next;
    logic               out_valid_reg, out_valid_next;

    // Working registers for the row being processed.
    logic [1:0]         func_reg, func_next;
    logic [LED_W-1:0]   led_reg, led_next;
    logic [PAT_W-1:0]   pat_reg, pat_next;
    logic [GUARD_W-1:0] guard_reg, guard_next;
    logic [PATTERN_COUNT-1:0][pls_pkg::CODE_W-1:0] pos_reg, pos_next;
    pls_pkg::led_ctl_t  ctl_reg, ctl_next;
    pls_pkg::out_item_t out_item_reg, out_item_next;

    // Memory port signals.
    logic               mem_wr_en;
    logic               mem_rd_en;
    logic [ROW_W-1:0]   mem_rd_data;
    logic               mem_rd_valid;

    // Step unit signals.
    logic [PATTERN_COUNT-1:0][pls_pkg::CODE_W-1:0] step_pos;
    pls_pkg::led_ctl_t    step_ctl;
    pls_pkg::step_flags_t step_flags;

    logic in_accept;

    // Each LED owns one row: the step positions of all its patterns followed
    // by the active pattern, the countdown and the level.
    pls_row_mem #(
        .DEPTH  (LED_COUNT),
        .WIDTH  (ROW_W),
        .ADDR_W (LED_W)
    ) u_row_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (mem_wr_en),
        .wr_addr  (led_reg),
        .wr_data  ({pos_reg, ctl_reg}),
        .rd_en    (mem_rd_en),
        .rd_addr  (led_reg),
        .rd_data  (mem_rd_data),
        .rd_valid (mem_rd_valid)
    );

    pls_step_unit #(
        .PATTERN_COUNT (PATTERN_COUNT),
        .PAT_W         (PAT_W)
    ) u_step_unit (
        .pos_in  (pos_reg),
        .ctl_in  (ctl_reg),
        .pos_out (step_pos),
        .ctl_out (step_ctl),
        .flags   (step_flags)
    );

    // Items are taken only while the sequencer is idle. A finished result
    // sits in the output register, so the next item can enter while it waits.
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        logic [PATTERN_COUNT-1:0][pls_pkg::CODE_W-1:0] rd_pos;
        pls_pkg::led_ctl_t    rd_ctl;
        logic [pls_pkg::CODE_W-1:0] act;
        logic                 in_range;

        state_next     = state_reg;
        lit_bits_next  = lit_bits_reg;
        run_bits_next  = run_bits_reg;
        out_valid_next = out_valid_reg && out_stall;
        func_next      = func_reg;
        led_next       = led_reg;
        pat_next       = pat_reg;
        guard_next     = guard_reg;
        pos_next       = pos_reg;
        ctl_next       = ctl_reg;
        out_item_next  = out_item_reg;
        mem_wr_en      = 1'b0;
        mem_rd_en      = 1'b0;
        act            = pls_pkg::CODE_NONE;

        // A row never written since reset reads as the reset row.
        if (mem_rd_valid)
        begin
            rd_pos = mem_rd_data[ROW_W-1:CTL_W];
            rd_ctl = mem_rd_data[CTL_W-1:0];
        end
        else
        begin
            rd_pos = {PATTERN_COUNT{pls_pkg::CODE_NONE}};
            rd_ctl = CTL_RESET;
        end

        in_range = (32'(in_item.led_index) < LED_COUNT)
                && (32'(in_item.pattern_index) < PATTERN_COUNT);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    func_next = in_item.func;
                    led_next  = LED_W'(in_item.led_index);
                    pat_next  = PAT_W'(in_item.pattern_index);
                    if (in_item.func == pls_pkg::FUNC_TICK)
                    begin
                        // A tick visits every LED in index order.
                        led_next   = '0;
                        state_next = ST_RD;
                    end
                    else if (((in_item.func == pls_pkg::FUNC_RUN)
                              || (in_item.func == pls_pkg::FUNC_STOP)) && in_range)
                    begin
                        state_next = ST_RD;
                    end
                    else
                    begin
                        // Unused function code or index out of range: the
                        // item only reports the current levels.
                        state_next = ST_FIN;
                    end
                end
            end

            ST_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = ST_LOAD;
            end

            ST_LOAD:
            begin
                pos_next   = rd_pos;
                ctl_next   = rd_ctl;
                guard_next = '0;
                state_next = ST_WB;
                if (func_reg == pls_pkg::FUNC_TICK)
                begin
                    if (rd_ctl.countdown != '0)
                    begin
                        ctl_next.countdown = rd_ctl.countdown - 1'b1;
                        if (rd_ctl.countdown == pls_pkg::MS_W'(1))
                        begin
                            state_next = ST_WALK;
                        end
                    end
                end
                else
                begin
                    // Run restarts the pattern, stop ends it; either way the
                    // LED goes dark and the active pattern is picked again.
                    if (func_reg == pls_pkg::FUNC_RUN)
                    begin
                        pos_next[pat_reg] = '0;
                    end
                    else
                    begin
                        pos_next[pat_reg] = pls_pkg::CODE_NONE;
                    end
                    for (int i = PATTERN_COUNT - 1; i >= 0; i--)
                    begin
                        if (pos_next[i] != pls_pkg::CODE_NONE)
                        begin
                            act = pls_pkg::CODE_W'(i);
                        end
                    end
                    ctl_next.active = act;
                    ctl_next.lit    = 1'b0;
                    // A run only walks if its pattern won the re-pick.
                    if ((func_reg == pls_pkg::FUNC_STOP)
                        || (act == pls_pkg::CODE_W'(pat_reg)))
                    begin
                        state_next = ST_WALK;
                    end
                end
            end

            ST_WALK:
            begin
                // One pattern step a cycle while walk_enable is set, until a timed wait is loaded, the
                // LED runs out of patterns or the step bound is hit.
                if (!walk_enable_reg)
                begin
                    state_next = ST_WB;
                end
                else
                begin
                    pos_next   = step_pos;
                    ctl_next   = step_ctl;
                    guard_next = guard_reg + 1'b1;
                    if (step_flags.done || (guard_reg == LAST_GUARD))
                    begin
                        state_next = ST_WB;
                    end
                end
            end

            ST_WB:
            begin
                // The row is written back here; the next read of any row is
                // issued no earlier than the following cycle, so a read never
                // meets a write in flight.
                mem_wr_en              = 1'b1;
                lit_bits_next[led_reg] = ctl_reg.lit;
                run_bits_next[led_reg] = (ctl_reg.countdown != '0);
                if ((func_reg == pls_pkg::FUNC_TICK) && (led_reg != LAST_LED))
                begin
                    led_next   = led_reg + 1'b1;
                    state_next = ST_RD;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    for (int i = 0; i < 4; i++)
                    begin
                        out_item_next.led_levels[i]  = 1'b0;
                        out_item_next.timing_mask[i] = 1'b0;
                        if (i < LED_COUNT)
                        begin
                            out_item_next.led_levels[i]  = lit_bits_reg[i];
                            out_item_next.timing_mask[i] = run_bits_reg[i];
                        end
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            walk_enable_reg <= 1'b1;
            lit_bits_reg    <= '0;
            run_bits_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lit_bits_reg  <= lit_bits_next;
            run_bits_reg  <= run_bits_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                walk_enable_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        led_reg      <= led_next;
        pat_reg      <= pat_next;
        guard_reg    <= guard_next;
        pos_reg      <= pos_next;
        ctl_reg      <= ctl_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // A new result only ever comes from the final state of an item.
    `PLS_ASSERT_IMP(a_result_from_fin, clk, rst_n, $rose(out_valid_reg), $past(state_reg == ST_FIN))
    // The sequencer never reads a row in the same cycle as it writes one.
    `PLS_ASSERT_IMP(a_no_rw_overlap, clk, rst_n, mem_wr_en, !mem_rd_en)
    // An accepted item either starts a row access or reports at once.
    `PLS_ASSERT_NXT(a_accept_moves, clk, rst_n, in_accept, (state_reg == ST_RD) || (state_reg == ST_FIN))
    // The walk bound is never overrun.
    `PLS_ASSERT_IMP(a_walk_bound, clk, rst_n, state_reg == ST_WALK, guard_reg <= LAST_GUARD)

endmodule

// ===== hdl/pls_row_mem.sv =====
`timescale 1ns / 1ps

// One row per LED, synchronous write, registered read. An entry that has
// not been written since reset is flagged through rd_valid.
module pls_row_mem #(
    parameter int DEPTH  = 4,
    parameter int WIDTH  = 33,
    parameter int ADDR_W = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    output logic              rd_valid
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] written_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

// ===== hdl/pls_step_unit.sv =====
`timescale 1ns / 1ps

// One step of a pattern walk for one LED, including the re-pick of the
// active pattern when a pattern runs into its stop step.
module pls_step_unit #(
    parameter int PATTERN_COUNT = pls_pkg::DEF_PATTERN_COUNT,
    parameter int PAT_W         = 3
) (
    input  logic [PATTERN_COUNT-1:0][pls_pkg::CODE_W-1:0] pos_in,
    input  pls_pkg::led_ctl_t                             ctl_in,
    output logic [PATTERN_COUNT-1:0][pls_pkg::CODE_W-1:0] pos_out,
    output pls_pkg::led_ctl_t                             ctl_out,
    output pls_pkg::step_flags_t                          flags
);

    always_comb
    begin
        logic [PAT_W-1:0]           pidx;
        logic [pls_pkg::CODE_W-1:0] pos;
        logic [pls_pkg::CODE_W-1:0] act;
        pls_pkg::step_t             st;

        pos_out    = pos_in;
        ctl_out    = ctl_in;
        flags.done = 1'b1;
        pidx       = PAT_W'(ctl_in.active);
        pos        = pls_pkg::CODE_NONE;
        act        = pls_pkg::CODE_NONE;
        st         = pls_pkg::STEP_STOP;

        if (32'(ctl_in.active) < PATTERN_COUNT)
        begin
            pos           = pos_in[pidx];
            st            = pls_pkg::rom_step(ctl_in.active, pos);
            pos_out[pidx] = pos + 3'd1;
            flags.done    = 1'b0;
            case (st.kind)
                pls_pkg::KIND_LOOP:
                begin
                    pos_out[pidx] = '0;
                end
                pls_pkg::KIND_WAIT:
                begin
                    ctl_out.lit = st.level;
                    if (st.ms != pls_pkg::MS_0)
                    begin
                        ctl_out.countdown = st.ms;
                        flags.done        = 1'b1;
                    end
                end
                default:
                begin
                    // Stop step: end this pattern and fall back to the next.
                    pos_out[pidx] = pls_pkg::CODE_NONE;
                    for (int i = PATTERN_COUNT - 1; i >= 0; i--)
                    begin
                        if (pos_out[i] != pls_pkg::CODE_NONE)
                        begin
                            act = pls_pkg::CODE_W'(i);
                        end
                    end
                    ctl_out.active = act;
                    ctl_out.lit    = 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== tb/sv/tb_priority_led_sequencer.sv =====
`timescale 1ns / 1ps

module tb_priority_led_sequencer;

    // Size of the block under test; the predictor is written for these.
    localparam int LEDS      = pls_pkg::DEF_LED_COUNT;
    localparam int PAT_LIMIT = (pls_pkg::DEF_PATTERN_COUNT < pls_pkg::ROM_PATTERNS) ?
                               pls_pkg::DEF_PATTERN_COUNT : pls_pkg::ROM_PATTERNS;

    // The one function code that the block leaves unused.
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    // A walk never takes more steps than this.
    localparam int STEP_GUARD = 16;

    // Quiet cycles allowed before a register write and at the end of the run.
    localparam int SETTLE_CYCLES = 100;

    // Hard stop for the whole run, several times the slowest correct run.
    localparam int CYCLE_LIMIT = 1000000;

    // Kinds of step held in the blink pattern table.
    typedef enum logic [1:0] {
        STEP_WAIT,
        STEP_LOOP,
        STEP_END
    } step_kind_t;

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic                 cfg_wr_data = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    pls_pkg::in_item_t    in_item     = '0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    pls_pkg::out_item_t   out_item;

    // Predicted state of the sequencer, one copy per LED.
    logic [pls_pkg::CODE_W-1:0] seq_pos    [LEDS][pls_pkg::ROM_PATTERNS];
    logic [pls_pkg::CODE_W-1:0] seq_active [LEDS];
    logic [pls_pkg::MS_W-1:0]   seq_count  [LEDS];
    logic                       seq_lit    [LEDS];
    logic                       model_walk_en;

    // LED outputs predicted for items that have been accepted but not yet answered.
    pls_pkg::out_item_t pending_led_outputs [$];

    int mismatches  = 0;
    int cycle_count = 0;

    // Sender pacing: items left in the current burst.
    int burst_left = 1;

    // Receiver back-pressure: a rotating 16-bit stall mask that is replaced periodically.
    logic [15:0] stall_mask  = '0;
    int          stall_phase = 0;

    priority_led_sequencer uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The run is cut short here if the block stops answering.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("priority_led_sequencer: mismatch");
            $finish;
        end
    end

    // The receiver stalls on a rotating mask. Some masks are empty, which gives
    // long stretches with no back-pressure at all; others stall on every bit of
    // the low half of the mask.
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 400 == 0)
        begin
            case ($urandom_range(0, 3))
                0: stall_mask <= '0;
                1: stall_mask <= 16'($urandom);
                2: stall_mask <= 16'($urandom & $urandom);
                default: stall_mask <= 16'h00FF;
            endcase
        end
        if (rst_n)
            out_stall <= stall_mask[stall_phase % 16];
    end

    // One line per mismatch, with the count kept for the final verdict. Printing
    // stops after a hundred lines so that a broken block cannot flood the log.
    task automatic report_mismatch(input string what, input logic [3:0] got,
                                   input logic [3:0] want);
        mismatches++;
        if (mismatches <= 100)
            $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Every accepted result is held against the oldest prediction. Values are
    // read at the clock edge itself, before the block updates its outputs.
    always @(posedge clk)
    begin
        pls_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_led_outputs.size() == 0)
            begin
                report_mismatch("result with no item outstanding",
                                out_item.led_levels, 4'h0);
            end
            else
            begin
                want = pending_led_outputs.pop_front();
                if (out_item.led_levels !== want.led_levels)
                    report_mismatch("led_levels", out_item.led_levels, want.led_levels);
                if (out_item.timing_mask !== want.timing_mask)
                    report_mismatch("timing_mask", out_item.timing_mask, want.timing_mask);
            end
        end
    end

    // The fixed blink patterns, ranked 0 (highest) to 5. A position past the
    // stored steps, or a pattern outside the table, reads as a stop step.
    function automatic void read_blink_step(input logic [pls_pkg::CODE_W-1:0] pat,
                                            input logic [pls_pkg::CODE_W-1:0] pos,
                                            output logic lvl,
                                            output step_kind_t kind,
                                            output logic [pls_pkg::MS_W-1:0] ms);
        lvl  = 1'b0;
        kind = STEP_END;
        ms   = '0;
        if (pos == 3'd0 && pat < 3'd6)
        begin
            lvl  = 1'b1;
            kind = STEP_WAIT;
            case (pat)
                3'd0, 3'd1: ms = 11'd1000;
                3'd2:       ms = 11'd200;
                3'd3, 3'd4: ms = 11'd50;
                default:    ms = 11'd1;
            endcase
        end
        else if (pos == 3'd1)
        begin
            case (pat)
                3'd0, 3'd1: kind = STEP_LOOP;
                3'd2: begin kind = STEP_WAIT; ms = 11'd800;  end
                3'd3: begin kind = STEP_WAIT; ms = 11'd450;  end
                3'd4: begin kind = STEP_WAIT; ms = 11'd1950; end
                3'd5: begin kind = STEP_WAIT; ms = 11'd0;    end
                default: kind = STEP_END;
            endcase
        end
        else if (pos == 3'd2)
        begin
            if (pat == 3'd2 || pat == 3'd3 || pat == 3'd4)
                kind = STEP_LOOP;
        end
    endfunction

    // Re-picks the highest-priority running pattern of an LED and turns the LED off.
    function automatic void pick_active(input int led);
        int p;
        seq_lit[led]    = 1'b0;
        seq_active[led] = pls_pkg::CODE_NONE;
        for (p = 0; p < PAT_LIMIT; p++)
        begin
            if (seq_pos[led][p] != pls_pkg::CODE_NONE)
            begin
                seq_active[led] = p[pls_pkg::CODE_W-1:0];
                break;
            end
        end
    endfunction

    // Walks the steps of an LED's active pattern until a timed step with a
    // non-zero wait loads the countdown, or nothing is left to run.
    function automatic void walk_led(input int led);
        int                         guard;
        logic [pls_pkg::CODE_W-1:0] p;
        logic [pls_pkg::CODE_W-1:0] pos;
        logic                       lvl;
        step_kind_t                 kind;
        logic [pls_pkg::MS_W-1:0]   ms;
        if (!model_walk_en)
            return;
        for (guard = 0; guard < STEP_GUARD; guard++)
        begin
            p = seq_active[led];
            if (32'(p) >= PAT_LIMIT)
                return;
            pos = seq_pos[led][p];
            read_blink_step(p, pos, lvl, kind, ms);
            seq_pos[led][p] = pos + 3'd1;
            case (kind)
                STEP_LOOP: seq_pos[led][p] = 3'd0;
                STEP_END:
                begin
                    seq_pos[led][p] = pls_pkg::CODE_NONE;
                    pick_active(led);
                end
                default:
                begin
                    seq_lit[led] = lvl;
                    if (ms != '0)
                    begin
                        seq_count[led] = ms;
                        return;
                    end
                end
            endcase
        end
    endfunction

    // Applies one item to the predicted state and returns the LED outputs it leaves.
    function automatic pls_pkg::out_item_t predict_led_outputs(input pls_pkg::in_item_t it);
        int                 i;
        int                 led;
        int                 pat;
        pls_pkg::out_item_t res;
        led = int'(it.led_index);
        pat = int'(it.pattern_index);
        if (it.func == pls_pkg::FUNC_TICK)
        begin
            for (i = 0; i < LEDS; i++)
            begin
                if (seq_count[i] != '0)
                begin
                    seq_count[i] = seq_count[i] - 11'd1;
                    if (seq_count[i] == '0)
                        walk_led(i);
                end
            end
        end
        else if ((it.func == pls_pkg::FUNC_RUN || it.func == pls_pkg::FUNC_STOP) &&
                 led < LEDS && pat < PAT_LIMIT)
        begin
            if (it.func == pls_pkg::FUNC_RUN)
            begin
                seq_pos[led][pat] = 3'd0;
                pick_active(led);
                if (seq_active[led] == it.pattern_index)
                    walk_led(led);
            end
            else
            begin
                seq_pos[led][pat] = pls_pkg::CODE_NONE;
                pick_active(led);
                walk_led(led);
            end
        end
        res = '0;
        for (i = 0; i < LEDS && i < 4; i++)
        begin
            res.led_levels[i]  = seq_lit[i];
            res.timing_mask[i] = (seq_count[i] != '0);
        end
        return res;
    endfunction

    // Presents one item, holds it until accepted, and records its prediction.
    // After each burst the sender may drop in_valid for a random gap; a gap of zero
    // joins two bursts into one longer stretch.
    task automatic send_led_command(input logic [1:0] func, input logic [1:0] led,
                                    input logic [2:0] pat);
        pls_pkg::in_item_t it;
        int                gap;
        it.func          = func;
        it.led_index     = led;
        it.pattern_index = pat;
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall);
        pending_led_outputs.push_back(predict_led_outputs(it));
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) :
                                                       $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Waits for every outstanding result, lets the block settle, then writes
    // the walk enable register.
    task automatic set_walk_enable(input logic value);
        in_valid <= 1'b0;
        while (pending_led_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en     <= 1'b1;
        cfg_wr_data   <= value;
        model_walk_en  = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly ticks, so that countdowns run out and patterns walk on, with runs
    // and stops sprinkled among them and a little noise: the spare function
    // code and pattern indexes beyond the table.
    task automatic drive_random_commands(input int count);
        int         n;
        int         pick;
        logic [2:0] pat;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            // The patterns with short lit steps, 3 to 5, are favoured so that whole cycles of them are seen.
            pat = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(3, 5)) :
                                                3'($urandom_range(0, PAT_LIMIT - 1));
            if (pick < 80)
                send_led_command(pls_pkg::FUNC_TICK, 2'($urandom_range(0, 3)),
                                 3'($urandom_range(0, 7)));
            else if (pick < 91)
                send_led_command(pls_pkg::FUNC_RUN, 2'($urandom_range(0, 3)), pat);
            else if (pick < 97)
                send_led_command(pls_pkg::FUNC_STOP, 2'($urandom_range(0, 3)), pat);
            else if (pick < 99)
                send_led_command(FUNC_SPARE, 2'($urandom_range(0, 3)),
                                 3'($urandom_range(0, 7)));
            else
                send_led_command(($urandom_range(0, 1) == 0) ? pls_pkg::FUNC_RUN :
                                                               pls_pkg::FUNC_STOP,
                                 2'($urandom_range(0, 3)), 3'($urandom_range(6, 7)));
        end
    endtask

    // Hand-picked items after reset, with walking enabled.
    task automatic test_directed_cases();
        int n;
        // A tick with nothing running, carrying ignored LED and pattern fields.
        send_led_command(pls_pkg::FUNC_TICK, 2'd3, 3'd7);
        // The shortest pattern: lit for one millisecond, then a zero wait that
        // carries straight on into its stop step, which ends it.
        send_led_command(pls_pkg::FUNC_RUN, 2'd0, 3'd5);
        send_led_command(pls_pkg::FUNC_TICK, 2'd0, 3'd0);
        // A highest-priority pattern on the last LED, then a lower one that
        // only clears the LED without taking over.
        send_led_command(pls_pkg::FUNC_RUN, 2'd3, 3'd0);
        send_led_command(pls_pkg::FUNC_RUN, 2'd3, 3'd2);
        // Stopping the top pattern hands the LED to the lower one at once.
        send_led_command(pls_pkg::FUNC_STOP, 2'd3, 3'd0);
        // With nothing left running, the countdown carries on regardless.
        send_led_command(pls_pkg::FUNC_STOP, 2'd3, 3'd2);
        // Items that must change nothing: the spare code and patterns out of range.
        send_led_command(FUNC_SPARE, 2'd2, 3'd3);
        send_led_command(pls_pkg::FUNC_RUN, 2'd1, 3'd6);
        send_led_command(pls_pkg::FUNC_STOP, 2'd2, 3'd7);
        send_led_command(pls_pkg::FUNC_RUN, 2'd2, 3'd4);
        send_led_command(pls_pkg::FUNC_RUN, 2'd1, 3'd1);
        send_led_command(pls_pkg::FUNC_RUN, 2'd0, 3'd3);
        // Stopping a pattern that never ran still re-picks and walks the LED,
        // which here passes the loop step and restarts the timed step.
        send_led_command(pls_pkg::FUNC_STOP, 2'd1, 3'd5);
        // A lower pattern restarted under a running higher one.
        send_led_command(pls_pkg::FUNC_RUN, 2'd2, 3'd5);
        send_led_command(pls_pkg::FUNC_RUN, 2'd2, 3'd3);
        for (n = 0; n < 8; n++)
            send_led_command(pls_pkg::FUNC_TICK, 2'($urandom_range(0, 3)),
                             3'($urandom_range(0, 7)));
    endtask

    // Long random run with walking enabled, so that patterns cycle through
    // their steps and countdowns outlive the patterns that loaded them.
    task automatic test_random_walking();
        drive_random_commands(700);
    endtask

    // With walking off, runs and stops only re-pick and clear the LEDs, while
    // countdowns still run out without walking anything.
    task automatic test_walk_disabled();
        set_walk_enable(1'b0);
        drive_random_commands(500);
    endtask

    // Walking back on, picking up from whatever the disabled phase left behind.
    task automatic test_walk_reenabled();
        set_walk_enable(1'b1);
        drive_random_commands(800);
    endtask

    initial
    begin
        int i;
        int p;
        // Predicted state after reset: every pattern stopped, LEDs dark and idle.
        model_walk_en = 1'b1;
        for (i = 0; i < LEDS; i++)
        begin
            for (p = 0; p < pls_pkg::ROM_PATTERNS; p++)
                seq_pos[i][p] = pls_pkg::CODE_NONE;
            seq_active[i] = pls_pkg::CODE_NONE;
            seq_count[i]  = '0;
            seq_lit[i]    = 1'b0;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_walking();
        test_walk_disabled();
        test_walk_reenabled();

        // Drain the remaining results, then watch for anything unexpected.
        in_valid <= 1'b0;
        while (pending_led_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("priority_led_sequencer: match");
        else
            $display("priority_led_sequencer: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/pls_pkg.sv
hdl/pls_row_mem.sv
hdl/pls_step_unit.sv
hdl/priority_led_sequencer.sv
tb/sv/tb_priority_led_sequencer.sv
